@@ rtl/core/dda_pkg.sv @@
// shared package for the differential drive odometry block
// holds fixed-point constants, the sequencer state type and the cordic arctangent table
// no dependencies
package dda_pkg;

	localparam int CORDIC_STEPS_DEFAULT = 24;
	localparam int DIV_BITS = 64;

	// register indexes on the configuration port
	localparam logic [1:0] REG_METERS_PER_TICK = 2'd0;
	localparam logic [1:0] REG_INV_WHEEL_BASE  = 2'd1;

	localparam logic [31:0] METERS_PER_TICK_RST = 32'd214175;
	localparam logic [31:0] INV_WHEEL_BASE_RST  = 32'd113743820;

	localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
	localparam logic signed [33:0] Q30_ONE      = 34'sd1073741824;
	localparam logic signed [33:0] RAD_TO_BAM   = 34'sd683565276;
	localparam logic signed [33:0] USEC_PER_SEC = 34'sd1000000;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL_TRAV,
		ST_MUL_DIFF,
		ST_SAT_DIFF,
		ST_MUL_R_HI,
		ST_MUL_R_LO,
		ST_ACC_R,
		ST_MUL_B_HI,
		ST_MUL_B_LO,
		ST_ACC_B,
		ST_ROT1_START,
		ST_ROT1_WAIT,
		ST_MUL_DX,
		ST_MUL_DY,
		ST_CAP_DY,
		ST_ACCUM,
		ST_ROT2_START,
		ST_ROT2_WAIT,
		ST_VEL_LO,
		ST_VEL_HI,
		ST_VEL_ACC,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_DONE
	} dda_state_t;

	// arctangent of 2^-k as binary angle
	function automatic logic [31:0] atan_bam(input logic [4:0] k);
		logic [31:0] v;
		begin
			unique case (k)
				5'd0: v = 32'h20000000;
				5'd1: v = 32'h12E4051E;
				5'd2: v = 32'h09FB385B;
				5'd3: v = 32'h051111D4;
				5'd4: v = 32'h028B0D43;
				5'd5: v = 32'h0145D7E1;
				5'd6: v = 32'h00A2F61E;
				5'd7: v = 32'h00517C55;
				5'd8: v = 32'h0028BE53;
				5'd9: v = 32'h00145F2F;
				5'd10: v = 32'h000A2F98;
				5'd11: v = 32'h000517CC;
				5'd12: v = 32'h00028BE6;
				5'd13: v = 32'h000145F3;
				5'd14: v = 32'h0000A2FA;
				5'd15: v = 32'h0000517D;
				5'd16: v = 32'h000028BE;
				5'd17: v = 32'h0000145F;
				5'd18: v = 32'h00000A30;
				5'd19: v = 32'h00000518;
				5'd20: v = 32'h0000028C;
				5'd21: v = 32'h00000146;
				5'd22: v = 32'h000000A3;
				5'd23: v = 32'h00000051;
				5'd24: v = 32'h00000029;
				5'd25: v = 32'h00000014;
				5'd26: v = 32'h0000000A;
				5'd27: v = 32'h00000005;
				5'd28: v = 32'h00000003;
				5'd29: v = 32'h00000001;
				5'd30: v = 32'h00000001;
				default: v = 32'h00000000;
			endcase
			return v;
		end
	endfunction

endpackage

@@ rtl/core/differential_drive_odometry.sv @@
// Differential drive odometry: each transaction of wheel encoder positions and elapsed
// microseconds advances the pose along the midpoint heading and returns pose, yaw
// quaternion and velocities. One item is handled at a time; the work on each transaction is
// dominated by three bit-serial divisions for the velocities and two passes of the
// iterative cordic unit; with zero elapsed time the divisions are skipped.
// A finished result is held in the output register, so the next transaction may be
// accepted while it waits. Configuration writes are taken at any time.
// depends on dda_pkg, dda_mul, dda_cordic, dda_div
module differential_drive_odometry #(
	parameter int CORDIC_STEPS = dda_pkg::CORDIC_STEPS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] left_position,
	input  logic signed [31:0] right_position,
	input  logic [31:0]        elapsed_us,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic [31:0]        heading,
	output logic signed [31:0] quat_w,
	output logic signed [31:0] quat_z,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic signed [31:0] yaw_rate,
	output logic               velocity_valid
);

	dda_pkg::dda_state_t state_q, state_d;

	logic [31:0]        mpt_q, iwb_q;
	logic [31:0]        x_q, y_q, head_q, prev_l_q, prev_r_q;
	logic [31:0]        lp_q, rp_q, el_q;
	logic [32:0]        sum_mag_q, diff_mag_q;
	logic               sum_neg_q, diff_neg_q;
	logic signed [31:0] dist_q;
	logic [46:0]        md_q;
	logic [55:0]        r_q;
	logic [32:0]        bam_q;
	logic [31:0]        dbam_q;
	logic signed [31:0] c_q, s_q, w_q, qz_q;
	logic signed [32:0] dx_q, dy_q;
	logic [63:0]        num_q;
	logic [1:0]         idx_q;
	logic signed [31:0] vx_q, vy_q, vyaw_q;
	logic               ovalid_q;
	logic signed [31:0] o_x_q, o_y_q, o_w_q, o_qz_q, o_vx_q, o_vy_q, o_vyaw_q;
	logic [31:0]        o_head_q;
	logic               o_vv_q;

	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] prod;
	logic               rot_start, div_start, rot_done, div_done;
	logic [31:0]        rot_angle;
	logic signed [31:0] rot_cos, rot_sin;
	logic [63:0]        quo;
	logic               in_acc, out_load;
	logic [31:0]        dl, dr, hbam, dbam, hh;
	logic signed [32:0] sum_s, diff_s, dx_mag, dy_mag;
	logic               vneg;
	logic signed [31:0] vsat;

	dda_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	dda_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rot_start),
		.angle   (rot_angle),
		.done    (rot_done),
		.cos_out (rot_cos),
		.sin_out (rot_sin)
	);

	dda_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (num_q),
		.divisor  (el_q),
		.done     (div_done),
		.quotient (quo)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == dda_pkg::ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_load  = (state_q == dda_pkg::ST_DONE) && (!ovalid_q || out_ready);

	// tick deltas, wheel sum and difference
	always_comb begin
		dl     = lp_q - prev_l_q;
		dr     = rp_q - prev_r_q;
		sum_s  = {dl[31], dl} + {dr[31], dr};
		diff_s = {dr[31], dr} - {dl[31], dl};
	end

	// heading change and half change as binary angles
	always_comb begin
		dbam = diff_neg_q ? -bam_q[31:0] : bam_q[31:0];
		hbam = diff_neg_q ? -bam_q[32:1] : bam_q[32:1];
		hh   = {head_q[31], head_q[31:1]};
		dx_mag = dx_q[32] ? -dx_q : dx_q;
		dy_mag = dy_q[32] ? -dy_q : dy_q;
	end

	// velocity sign and saturation of the quotient
	always_comb begin
		case (idx_q)
			2'd0:    vneg = dx_q[32];
			2'd1:    vneg = dy_q[32];
			default: vneg = diff_neg_q;
		endcase
		if (vneg) begin
			if ((|quo[63:32]) || (quo[31] && (|quo[30:0]))) begin
				vsat = 32'sh8000_0000;
			end else begin
				vsat = -$signed(quo[31:0]);
			end
		end else begin
			if (|quo[63:31]) begin
				vsat = 32'sh7FFF_FFFF;
			end else begin
				vsat = $signed(quo[31:0]);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dda_pkg::ST_IDLE:       if (in_acc) state_d = dda_pkg::ST_PREP;
			dda_pkg::ST_PREP:       state_d = dda_pkg::ST_MUL_TRAV;
			dda_pkg::ST_MUL_TRAV:   state_d = dda_pkg::ST_MUL_DIFF;
			dda_pkg::ST_MUL_DIFF:   state_d = dda_pkg::ST_SAT_DIFF;
			dda_pkg::ST_SAT_DIFF:   state_d = dda_pkg::ST_MUL_R_HI;
			dda_pkg::ST_MUL_R_HI:   state_d = dda_pkg::ST_MUL_R_LO;
			dda_pkg::ST_MUL_R_LO:   state_d = dda_pkg::ST_ACC_R;
			dda_pkg::ST_ACC_R:      state_d = dda_pkg::ST_MUL_B_HI;
			dda_pkg::ST_MUL_B_HI:   state_d = dda_pkg::ST_MUL_B_LO;
			dda_pkg::ST_MUL_B_LO:   state_d = dda_pkg::ST_ACC_B;
			dda_pkg::ST_ACC_B:      state_d = dda_pkg::ST_ROT1_START;
			dda_pkg::ST_ROT1_START: state_d = dda_pkg::ST_ROT1_WAIT;
			dda_pkg::ST_ROT1_WAIT:  if (rot_done) state_d = dda_pkg::ST_MUL_DX;
			dda_pkg::ST_MUL_DX:     state_d = dda_pkg::ST_MUL_DY;
			dda_pkg::ST_MUL_DY:     state_d = dda_pkg::ST_CAP_DY;
			dda_pkg::ST_CAP_DY:     state_d = dda_pkg::ST_ACCUM;
			dda_pkg::ST_ACCUM:      state_d = dda_pkg::ST_ROT2_START;
			dda_pkg::ST_ROT2_START: state_d = dda_pkg::ST_ROT2_WAIT;
			dda_pkg::ST_ROT2_WAIT: begin
				if (rot_done) begin
					state_d = (el_q == '0) ? dda_pkg::ST_DONE : dda_pkg::ST_VEL_LO;
				end
			end
			dda_pkg::ST_VEL_LO:     state_d = dda_pkg::ST_VEL_HI;
			dda_pkg::ST_VEL_HI:     state_d = dda_pkg::ST_VEL_ACC;
			dda_pkg::ST_VEL_ACC:    state_d = dda_pkg::ST_DIV_START;
			dda_pkg::ST_DIV_START:  state_d = dda_pkg::ST_DIV_WAIT;
			dda_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = (idx_q == 2'd2) ? dda_pkg::ST_DONE : dda_pkg::ST_VEL_LO;
				end
			end
			dda_pkg::ST_DONE:       if (out_load) state_d = dda_pkg::ST_IDLE;
			default:                state_d = dda_pkg::ST_IDLE;
		endcase
	end

	// unit controls and multiplier operands
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		rot_start = 1'b0;
		rot_angle = head_q + hbam;
		div_start = 1'b0;
		unique case (state_q)
			dda_pkg::ST_MUL_TRAV: begin
				mul_a = {1'b0, sum_mag_q};
				mul_b = {2'b00, mpt_q};
			end
			dda_pkg::ST_MUL_DIFF: begin
				mul_a = {1'b0, diff_mag_q};
				mul_b = {2'b00, mpt_q};
			end
			dda_pkg::ST_MUL_R_HI: begin
				mul_a = {19'b0, md_q[46:32]};
				mul_b = {2'b00, iwb_q};
			end
			dda_pkg::ST_MUL_R_LO: begin
				mul_a = {2'b00, md_q[31:0]};
				mul_b = {2'b00, iwb_q};
			end
			dda_pkg::ST_MUL_B_HI: begin
				mul_a = {10'b0, r_q[55:32]};
				mul_b = dda_pkg::RAD_TO_BAM;
			end
			dda_pkg::ST_MUL_B_LO: begin
				mul_a = {2'b00, r_q[31:0]};
				mul_b = dda_pkg::RAD_TO_BAM;
			end
			dda_pkg::ST_ROT1_START: rot_start = 1'b1;
			dda_pkg::ST_MUL_DX: begin
				mul_a = {{2{dist_q[31]}}, dist_q};
				mul_b = {{2{c_q[31]}}, c_q};
			end
			dda_pkg::ST_MUL_DY: begin
				mul_a = {{2{dist_q[31]}}, dist_q};
				mul_b = {{2{s_q[31]}}, s_q};
			end
			dda_pkg::ST_ROT2_START: begin
				rot_start = 1'b1;
				rot_angle = hh;
			end
			dda_pkg::ST_VEL_LO: begin
				case (idx_q)
					2'd0:    mul_a = {1'b0, dx_mag};
					2'd1:    mul_a = {1'b0, dy_mag};
					default: mul_a = {2'b00, r_q[47:16]};
				endcase
				mul_b = dda_pkg::USEC_PER_SEC;
			end
			dda_pkg::ST_VEL_HI: begin
				mul_a = (idx_q == 2'd2) ? {26'b0, r_q[55:48]} : '0;
				mul_b = dda_pkg::USEC_PER_SEC;
			end
			dda_pkg::ST_DIV_START: div_start = 1'b1;
			default: ;
		endcase
	end

	// state, configuration, accumulators and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= dda_pkg::ST_IDLE;
			mpt_q    <= dda_pkg::METERS_PER_TICK_RST;
			iwb_q    <= dda_pkg::INV_WHEEL_BASE_RST;
			x_q      <= '0;
			y_q      <= '0;
			head_q   <= '0;
			prev_l_q <= '0;
			prev_r_q <= '0;
			ovalid_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					dda_pkg::REG_METERS_PER_TICK: mpt_q <= cfg_data;
					dda_pkg::REG_INV_WHEEL_BASE:  iwb_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == dda_pkg::ST_PREP) begin
				prev_l_q <= lp_q;
				prev_r_q <= rp_q;
			end
			if (state_q == dda_pkg::ST_ACCUM) begin
				x_q    <= x_q + dx_q[31:0];
				y_q    <= y_q + dy_q[31:0];
				head_q <= head_q + dbam_q;
			end
			if (in_acc) begin
				idx_q <= '0;
			end else if ((state_q == dda_pkg::ST_DIV_WAIT) && div_done) begin
				idx_q <= idx_q + 1'b1;
			end
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			lp_q   <= left_position;
			rp_q   <= right_position;
			el_q   <= elapsed_us;
			vx_q   <= '0;
			vy_q   <= '0;
			vyaw_q <= '0;
		end
		unique case (state_q)
			dda_pkg::ST_PREP: begin
				sum_neg_q  <= sum_s[32];
				diff_neg_q <= diff_s[32];
				sum_mag_q  <= sum_s[32] ? -sum_s : sum_s;
				diff_mag_q <= diff_s[32] ? -diff_s : diff_s;
			end
			// travel in Q16.16, magnitude saturated
			dda_pkg::ST_MUL_DIFF: begin
				if (|prod[66:48]) begin
					dist_q <= sum_neg_q ? -32'sh7FFF_FFFF : 32'sh7FFF_FFFF;
				end else begin
					dist_q <= sum_neg_q ? -$signed({1'b0, prod[47:17]})
						: $signed({1'b0, prod[47:17]});
				end
			end
			dda_pkg::ST_SAT_DIFF: md_q <= (|prod[66:47]) ? '1 : prod[46:0];
			dda_pkg::ST_MUL_R_LO: r_q <= {1'b0, prod[46:0], 8'b0};
			dda_pkg::ST_ACC_R:    r_q <= r_q + {16'b0, prod[63:24]};
			dda_pkg::ST_MUL_B_LO: bam_q <= prod[32:0];
			dda_pkg::ST_ACC_B:    bam_q <= bam_q + prod[64:32];
			dda_pkg::ST_ROT1_START: dbam_q <= dbam;
			dda_pkg::ST_ROT1_WAIT: begin
				if (rot_done) begin
					c_q <= rot_cos;
					s_q <= rot_sin;
				end
			end
			dda_pkg::ST_MUL_DY: dx_q <= prod[62:30];
			dda_pkg::ST_CAP_DY: dy_q <= prod[62:30];
			dda_pkg::ST_ROT2_WAIT: begin
				if (rot_done) begin
					w_q  <= rot_cos;
					qz_q <= rot_sin;
				end
			end
			dda_pkg::ST_VEL_HI:  num_q <= prod[63:0];
			dda_pkg::ST_VEL_ACC: num_q <= num_q + {prod[31:0], 32'b0};
			dda_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					case (idx_q)
						2'd0:    vx_q   <= vsat;
						2'd1:    vy_q   <= vsat;
						default: vyaw_q <= vsat;
					endcase
				end
			end
			default: ;
		endcase
		if (out_load) begin
			o_x_q    <= x_q;
			o_y_q    <= y_q;
			o_head_q <= head_q;
			o_w_q    <= w_q;
			o_qz_q   <= qz_q;
			o_vx_q   <= vx_q;
			o_vy_q   <= vy_q;
			o_vyaw_q <= vyaw_q;
			o_vv_q   <= (el_q != '0);
		end
	end

	assign out_valid      = ovalid_q;
	assign pos_x          = o_x_q;
	assign pos_y          = o_y_q;
	assign heading        = o_head_q;
	assign quat_w         = o_w_q;
	assign quat_z         = o_qz_q;
	assign vel_x          = o_vx_q;
	assign vel_y          = o_vy_q;
	assign yaw_rate       = o_vyaw_q;
	assign velocity_valid = o_vv_q;

endmodule

@@ rtl/core/dda_mul.sv @@
// shared registered multiplier, signed 34 by 34 bits
// depends on nothing
module dda_mul (
	input  logic                clk,
	input  logic signed [33:0]  a,
	input  logic signed [33:0]  b,
	output logic signed [67:0]  p
);

	logic signed [67:0] p_q;

	// product registered
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

@@ rtl/core/dda_cordic.sv @@
// iterative cordic rotator, one micro-rotation per cycle
// depends on dda_pkg for the gain and the arctangent table
module dda_cordic #(
	parameter int STEPS = dda_pkg::CORDIC_STEPS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [31:0]        angle,
	output logic               done,
	output logic signed [31:0] cos_out,
	output logic signed [31:0] sin_out
);

	localparam int CW = $clog2(STEPS);

	logic                run_q, fin_q, done_q, flip_q;
	logic [CW-1:0]       cnt_q;
	logic signed [33:0]  x_q, y_q, z_q;
	logic signed [31:0]  cos_q, sin_q;
	logic signed [33:0]  sx, sy, at, xf, yf;
	logic [31:0]         ang_rot, ang_fold;
	logic                flip;

	// fold the angle into the right half plane
	always_comb begin
		ang_rot  = angle + 32'h4000_0000;
		flip     = ang_rot[31];
		ang_fold = angle ^ {flip, 31'b0};
	end

	// shifted terms for the current step
	always_comb begin
		sx = y_q >>> cnt_q;
		sy = x_q >>> cnt_q;
		at = {2'b00, dda_pkg::atan_bam(5'(cnt_q))};
		xf = flip_q ? -x_q : x_q;
		yf = flip_q ? -y_q : y_q;
	end

	function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
		logic signed [33:0] r;
		begin
			if (v > dda_pkg::Q30_ONE) begin
				r = dda_pkg::Q30_ONE;
			end else if (v < -dda_pkg::Q30_ONE) begin
				r = -dda_pkg::Q30_ONE;
			end else begin
				r = v;
			end
			return r[31:0];
		end
	endfunction

	// control: run STEPS micro-rotations, then unfold and clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CW'(STEPS - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= dda_pkg::CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= {{2{ang_fold[31]}}, ang_fold};
			flip_q <= flip;
		end else if (run_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - sx;
				y_q <= y_q + sy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + sx;
				y_q <= y_q - sy;
				z_q <= z_q + at;
			end
		end else if (fin_q) begin
			cos_q <= clamp_q30(xf);
			sin_q <= clamp_q30(yf);
		end
	end

	assign done    = done_q;
	assign cos_out = cos_q;
	assign sin_out = sin_q;

endmodule

@@ rtl/core/dda_div.sv @@
// restoring divider, one quotient bit per cycle, 64 by 32 bits unsigned
// depends on dda_pkg for the dividend width
module dda_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);

	logic        run_q, done_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q, den_q;
	logic [63:0] quo_q;
	logic [32:0] sh, sub;
	logic        ge;

	// trial subtraction
	always_comb begin
		sh  = {rem_q, quo_q[63]};
		sub = sh - {1'b0, den_q};
		ge  = sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == 6'(dda_pkg::DIV_BITS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// dividend shifts out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? sub[31:0] : sh[31:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
